// File: rtl/imp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_pkg
// Types and codes shared by the integer matrix product block.
// ----------------------------------------------------------------------------
package imp_pkg;

    localparam int DIM_W   = 5;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 32;
    localparam int MAX_DIM = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_WRITE_A = 2'd0,
        MODE_WRITE_B = 2'd1,
        MODE_REQUEST = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] element_value;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] product_value;
        logic                     index_error;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } mac_ctrl_t;

endpackage

// File: rtl/integer_matrix_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_product
// Square integer matrix product C = A x B; element writes and C element reads.
// Operation: an in-range write stores its element in the A or B RAM. An in-range
//   request is computed one multiply-accumulate per cycle (dim saturated at 16)
//   through a single shared MAC fed by the A and B RAM read ports; an out-of-range
//   request gives an index_error response with a zero product.
// Throughput: one write per cycle while idle; no beat is taken during a request.
// Reset: rst_n asynchronous, active low; dim returns to 16, RAM contents undefined.
// ----------------------------------------------------------------------------
module integer_matrix_product (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [imp_pkg::DIM_W-1:0]        cfg_dim,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  imp_pkg::req_item_t               req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output imp_pkg::rsp_item_t               rsp_data
);

    import imp_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [DIM_W-1:0]  eff_dim;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              err_reg, err_next;
    logic              in_range;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_data_reg, rsp_data_next;

    logic              a_we, b_we, rd_en;
    logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
    logic [DATA_W-1:0] a_rdata, b_rdata, acc;
    logic              mac_busy;
    mac_ctrl_t         mac_ctrl;

    // dim above MAX_DIM saturates
    assign eff_dim  = (int'(dim_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_reg;
    assign in_range = ({1'b0, req_data.row_index} < eff_dim) &&
                      ({1'b0, req_data.col_index} < eff_dim);

    assign waddr   = ADDR_W'(int'(req_data.row_index) * MAX_DIM + int'(req_data.col_index));
    assign a_raddr = ADDR_W'(int'(row_reg) * MAX_DIM + int'(k_reg));
    assign b_raddr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(col_reg));

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            dim_reg <= cfg_dim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        err_reg      <= err_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        err_next       = err_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        rd_en          = 1'b0;
        mac_ctrl       = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_data.mode)
                        MODE_WRITE_A: a_we = in_range;
                        MODE_WRITE_B: b_we = in_range;
                        MODE_REQUEST:
                        begin
                            row_next       = req_data.row_index;
                            col_next       = req_data.col_index;
                            k_next         = '0;
                            err_next       = !in_range;
                            mac_ctrl.clear = 1'b1;
                            state_next     = in_range ? ST_RUN : ST_PUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                rd_en         = 1'b1;
                mac_ctrl.step = 1'b1;
                k_next        = k_reg + 1'b1;
                if (k_reg == eff_dim - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                // result waits here while the previous beat is still unread
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.index_error   = err_reg;
                    rsp_data_next.product_value = err_reg ? '0 : acc;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    imp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (req_data.element_value),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (req_data.element_value),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    imp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .acc    (acc),
        .busy   (mac_busy)
    );

endmodule

// File: rtl/imp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module imp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/imp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_mac
// Shared multiply-accumulate unit: registered 32x32 product, then wrapped add.
// ----------------------------------------------------------------------------
module imp_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imp_pkg::mac_ctrl_t            ctrl,
    input  logic [imp_pkg::DATA_W-1:0]    a_data,
    input  logic [imp_pkg::DATA_W-1:0]    b_data,
    output logic [imp_pkg::DATA_W-1:0]    acc,
    output logic                          busy
);

    import imp_pkg::*;

    logic              rv_reg;     // RAM data valid this cycle
    logic              pv_reg;     // product register valid
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] prod_next;
    logic [DATA_W-1:0] acc_reg;

    // only the low word of the product is kept
    assign prod_next = a_data * b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= ctrl.step;
            pv_reg <= rv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rv_reg)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = rv_reg | pv_reg;

endmodule

// File: tb/sv/integer_matrix_product_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_product_test
// Self-checking bench for the matrix product block. Element writes and product
// requests go in over the request channel; a scoreboard keeps its own copy of
// both operand stores and the dimension, computes each product element and
// checks every response beat in order. Runs a directed pass, then random
// traffic under several dimension settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module integer_matrix_product_test;

    import imp_pkg::*;

    localparam int STORE_WORDS   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W        = $clog2(STORE_WORDS);
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BEATS   = 50;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] DATA_ONES = 32'hFFFF_FFFF;

    function automatic logic [ADDR_W-1:0] store_addr(int row, int col);
        return ADDR_W'(row * MAX_DIM + col);
    endfunction

    class matrix_scoreboard;
        logic [DATA_W-1:0] a_mem [STORE_WORDS];
        logic [DATA_W-1:0] b_mem [STORE_WORDS];
        logic [DIM_W-1:0]  dim_reg;
        rsp_item_t         product_q [$];
        int                errors;

        function new();
            dim_reg = DIM_RESET;
            errors = 0;
            foreach (a_mem[i])
            begin
                a_mem[i] = '0;
                b_mem[i] = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int eff_dim();
            return (int'(dim_reg) > MAX_DIM) ? MAX_DIM : int'(dim_reg);
        endfunction

        function void set_dim(logic [DIM_W-1:0] d);
            dim_reg = d;
        endfunction

        function int pending();
            return product_q.size();
        endfunction

        // Update stores or queue the expected product for one accepted beat.
        function void note_input(req_item_t it);
            int n;
            bit in_range;
            logic [DATA_W-1:0] acc;
            rsp_item_t exp_rsp;
            n = eff_dim();
            in_range = (int'(it.row_index) < n) && (int'(it.col_index) < n);
            case (it.mode)
                MODE_WRITE_A:
                    if (in_range)
                        a_mem[store_addr(int'(it.row_index), int'(it.col_index))] =
                            it.element_value;
                MODE_WRITE_B:
                    if (in_range)
                        b_mem[store_addr(int'(it.row_index), int'(it.col_index))] =
                            it.element_value;
                MODE_REQUEST:
                begin
                    acc = '0;
                    if (in_range)
                    begin
                        for (int k = 0; k < n; k++)
                            acc = acc + a_mem[store_addr(int'(it.row_index), k)]
                                      * b_mem[store_addr(k, int'(it.col_index))];
                    end
                    exp_rsp.product_value = in_range ? acc : '0;
                    exp_rsp.index_error = !in_range;
                    product_q.push_back(exp_rsp);
                end
                default: ;
            endcase
        endfunction

        task check_result(rsp_item_t got);
            rsp_item_t exp_rsp;
            if (product_q.size() == 0)
            begin
                report($sformatf("unexpected beat product=%h err=%b",
                                 got.product_value, got.index_error));
                return;
            end
            exp_rsp = product_q.pop_front();
            if (got.product_value !== exp_rsp.product_value)
                report($sformatf("product_value got %h want %h",
                                 got.product_value, exp_rsp.product_value));
            if (got.index_error !== exp_rsp.index_error)
                report($sformatf("index_error got %b want %b",
                                 got.index_error, exp_rsp.index_error));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [DIM_W-1:0]    cfg_dim;
    logic                req_valid;
    logic                req_ready;
    req_item_t           req_data;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_item_t           rsp_data;

    matrix_scoreboard sb = new();
    bit a_written [STORE_WORDS];
    bit b_written [STORE_WORDS];
    bit quiet;
    int sent_items;

    integer_matrix_product dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_dim(cfg_dim),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return DATA_ONES;
            2: return DATA_MAX;
            3: return DATA_MIN;
            4: return DATA_W'(1);
            default: return $urandom;
        endcase
    endfunction

    function logic [IDX_W-1:0] pick_index(int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, MAX_DIM - 1));
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    // Response side: random backpressure, check each beat taken.
    initial
    begin
        int stall;
        stall = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_result(rsp_data);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task send_item(input req_item_t it);
        int gap;
        int n;
        logic [ADDR_W-1:0] addr;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        n = sb.eff_dim();
        addr = store_addr(int'(it.row_index), int'(it.col_index));
        if (int'(it.row_index) < n && int'(it.col_index) < n)
        begin
            if (it.mode == MODE_WRITE_A)
                a_written[addr] = 1'b1;
            else if (it.mode == MODE_WRITE_B)
                b_written[addr] = 1'b1;
        end
        sb.note_input(it);
        sent_items++;
    endtask

    task put_write(input mode_t m, input int row, input int col,
                   input logic [DATA_W-1:0] v);
        req_item_t it;
        it.mode = m;
        it.row_index = IDX_W'(row);
        it.col_index = IDX_W'(col);
        it.element_value = v;
        send_item(it);
    endtask

    // Writes any operand entry the dot product would touch that was never set.
    task put_request(input int row, input int col);
        req_item_t it;
        int n;
        n = sb.eff_dim();
        if (row < n && col < n)
        begin
            for (int k = 0; k < n; k++)
            begin
                if (!a_written[store_addr(row, k)])
                    put_write(MODE_WRITE_A, row, k, rand_value());
                if (!b_written[store_addr(k, col)])
                    put_write(MODE_WRITE_B, k, col, rand_value());
            end
        end
        it.mode = MODE_REQUEST;
        it.row_index = IDX_W'(row);
        it.col_index = IDX_W'(col);
        it.element_value = $urandom;
        send_item(it);
    endtask

    task drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task configure(input logic [DIM_W-1:0] d);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_dim <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_dim(d);
        cfg_valid <= 1'b0;
    endtask

    task run_random(input int target);
        int start_items;
        int n;
        int r;
        req_item_t it;
        start_items = sent_items;
        while (sent_items - start_items < target)
        begin
            n = sb.eff_dim();
            r = $urandom_range(0, 99);
            it.element_value = rand_value();
            it.row_index = pick_index(n);
            it.col_index = pick_index(n);
            if (r < 6)
            begin
                it.mode = mode_t'(MODE_UNUSED);
                send_item(it);
            end
            else if (r < 60)
            begin
                it.mode = (r < 33) ? MODE_WRITE_A : MODE_WRITE_B;
                send_item(it);
            end
            else
            begin
                put_request(int'(it.row_index), int'(it.col_index));
            end
            if ($urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [DIM_W-1:0] phase_dims [8];
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_dim <= DIM_RESET;
        req_valid <= 1'b0;
        req_data <= '0;
        quiet = 1'b0;
        sent_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dimension
        put_write(MODE_WRITE_A, 0, 0, DATA_MAX);
        put_write(MODE_WRITE_B, 0, 0, DATA_MAX);
        put_request(0, 0);
        put_write(mode_t'(MODE_UNUSED), 15, 15, DATA_ONES);
        put_request(15, 15);

        configure(DIM_W'(1));
        put_write(MODE_WRITE_A, 0, 0, DATA_MIN);
        put_write(MODE_WRITE_B, 0, 0, DATA_MIN);
        put_request(0, 0);
        put_write(MODE_WRITE_A, 0, 0, DATA_ONES);
        put_write(MODE_WRITE_B, 0, 0, DATA_ONES);
        put_write(MODE_WRITE_A, 0, 1, DATA_MAX);
        put_write(MODE_WRITE_B, 1, 0, DATA_MAX);
        put_request(0, 0);
        put_request(0, 1);
        put_request(1, 0);
        put_request(15, 15);

        // zero dimension: all indices out of range, writes dropped
        configure('0);
        put_request(0, 0);
        put_write(MODE_WRITE_A, 0, 0, DATA_W'(5));
        configure(DIM_W'(1));
        put_request(0, 0);

        phase_dims = '{DIM_W'(31), DIM_W'(3), DIM_W'(17), DIM_W'(0), DIM_W'(16),
                       DIM_W'(1), DIM_W'($urandom_range(0, 31)),
                       DIM_W'($urandom_range(2, 15))};
        foreach (phase_dims[p])
        begin
            configure(phase_dims[p]);
            quiet = ($urandom_range(0, 3) == 0);
            run_random((phase_dims[p] == 0) ? 15 : PHASE_BEATS);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/imp_pkg.sv
rtl/imp_ram.sv
rtl/imp_mac.sv
rtl/integer_matrix_product.sv
tb/sv/integer_matrix_product_test.sv
